@@ hdl/rtph_pkg.sv @@
// ----------------------------------------------------------------------------
// rtph_pkg: shared types and constants of the RTP H.264/H.265 depacketiser
// Word formats of both channels, the burst record that passes from the
// classifier to the serialiser, and the protocol constants of RTP and both
// NAL unit formats.
// ----------------------------------------------------------------------------
package rtph_pkg;

	localparam int MAX_PACKET_BYTES_DEF = 2048;
	localparam int QUEUE_DEPTH = 4;

	// RTP fixed header
	localparam logic [7:0]  RTP_VERSION_MASK = 8'h80;
	localparam logic [7:0]  RTP_SECOND_MASK  = 8'h60;
	localparam logic [11:0] RTP_HDR_BYTES    = 12'd12;

	// NAL unit header fields
	localparam logic [7:0] H264_TYPE_MASK  = 8'h1F;
	localparam logic [5:0] H265_TYPE_MASK  = 6'h3F;
	localparam logic [7:0] H264_FU_A       = 8'd28;
	localparam logic [5:0] H265_FU         = 6'd49;
	localparam logic [7:0] H264_HDR_KEEP   = 8'hE0;
	localparam logic [7:0] H265_HDR_KEEP   = 8'h81;
	localparam logic [7:0] H265_HDR_SECOND = 8'h01;
	localparam logic [7:0] START_CODE_LAST = 8'h01;
	localparam logic [7:0] START_CODE_ZERO = 8'h00;

	typedef enum logic [1:0] {
		KIND_PLAIN   = 2'd0,
		KIND_FU_A    = 2'd1,
		KIND_FU_H265 = 2'd2
	} unit_kind_t;

	typedef struct packed {
		logic [7:0]  in_byte;
		logic [11:0] packet_length;
	} pkt_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       seq_gap;
		logic       continuation_fragment;
	} seg_word_t;

	// Output bytes caused by one input byte: an optional start code followed
	// by up to two literal bytes, all carrying the same flags.
	typedef struct packed {
		logic       start_code;
		logic [1:0] n_bytes;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic       last;
		logic       gap;
		logic       cont;
	} burst_t;

	function automatic logic [2:0] burst_len(input burst_t bu);
		return {bu.start_code, 2'b00} + {1'b0, bu.n_bytes};
	endfunction

endpackage

@@ hdl/rtph_front.sv @@
// ----------------------------------------------------------------------------
// rtph_front: packet parser and classifier
// Tracks the byte position in the packet, the RTP sequence number and the
// kind of NAL unit, and turns each accepted byte into a burst record.
// ----------------------------------------------------------------------------
module rtph_front #(
	parameter int MAX_PACKET_BYTES = rtph_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pkt_valid,
	output logic               pkt_stall,
	input  rtph_pkg::pkt_word_t pkt_word,
	input  logic               q_full,
	output logic               push,
	output rtph_pkg::burst_t   burst
);
	import rtph_pkg::*;

	localparam logic [16:0] MAX_W = 17'(MAX_PACKET_BYTES);

	logic [11:0] pos_q, pos_n;
	logic [7:0]  held_q, held_n;
	logic        rtp_q, rtp_n;
	logic [7:0]  nal_q, nal_n;
	unit_kind_t  kind_q, kind_n;
	logic [7:0]  seqhi_q, seqhi_n;
	logic [15:0] lastseq_q, lastseq_n;
	logic        gap_q, gap_n;
	logic        drop_q, drop_n;
	logic        fstart_q, fstart_n;

	logic        accept;
	logic [7:0]  b;
	logic [11:0] len;
	logic [11:0] eff;
	logic [12:0] p_inc;

	function automatic burst_t add_byte(input burst_t bu, input logic [7:0] x);
		burst_t r;
		r = bu;
		if (bu.n_bytes == 2'd0) begin
			r.byte0 = x;
		end else begin
			r.byte1 = x;
		end
		r.n_bytes = bu.n_bytes + 2'd1;
		return r;
	endfunction

	assign pkt_stall = q_full;
	assign accept    = pkt_valid && !q_full;
	assign b         = pkt_word.in_byte;
	assign len       = pkt_word.packet_length;
	assign eff       = ({5'd0, len} < MAX_W) ? len : MAX_W[11:0];
	assign p_inc     = {1'b0, pos_q} + 13'd1;

	always_comb begin
		logic        hdr_go;
		logic        body_go;
		logic [7:0]  hdr_byte;
		logic [3:0]  hdr_need;
		logic [11:0] rel;
		logic [15:0] seq;
		burst_t      bu;

		held_n    = held_q;
		rtp_n     = rtp_q;
		nal_n     = nal_q;
		kind_n    = kind_q;
		seqhi_n   = seqhi_q;
		lastseq_n = lastseq_q;
		gap_n     = gap_q;
		drop_n    = drop_q;
		fstart_n  = fstart_q;
		hdr_go    = 1'b0;
		body_go   = 1'b0;
		hdr_byte  = b;
		hdr_need  = 4'd0;
		seq       = {seqhi_q, b};
		bu        = '0;

		if (pos_q == 12'd0) begin
			gap_n    = 1'b0;
			fstart_n = 1'b0;
			kind_n   = KIND_PLAIN;
			rtp_n    = 1'b0;
			drop_n   = (eff <= RTP_HDR_BYTES);
			held_n   = b;
		end else if (pos_q < eff && !drop_q) begin
			if (pos_q == 12'd1) begin
				rtp_n = ((held_q & RTP_VERSION_MASK) != 8'd0) && ((b & RTP_SECOND_MASK) != 8'd0);
				if (!rtp_n) begin
					hdr_go   = 1'b1;
					hdr_byte = held_q;
				end
			end else begin
				if (pos_q == 12'd2) begin
					seqhi_n = b;
				end else if (pos_q == 12'd3) begin
					gap_n     = (lastseq_q != 16'd0) && ((lastseq_q + 16'd1) != seq);
					lastseq_n = seq;
				end
				if (!rtp_q) begin
					body_go = 1'b1;
				end else if (pos_q == RTP_HDR_BYTES) begin
					hdr_go   = 1'b1;
					hdr_byte = b;
				end else if (pos_q > RTP_HDR_BYTES) begin
					body_go = 1'b1;
				end
			end
		end

		// NAL header: classify, and either open a plain unit or check the
		// fragment is long enough to hold its FU header.
		if (hdr_go) begin
			nal_n = hdr_byte;
			if ((hdr_byte & H264_TYPE_MASK) == H264_FU_A) begin
				kind_n = KIND_FU_A;
			end else if ((hdr_byte[7:1] & {1'b0, H265_TYPE_MASK}) == {1'b0, H265_FU}) begin
				kind_n = KIND_FU_H265;
			end else begin
				kind_n = KIND_PLAIN;
			end
			hdr_need = (rtp_n ? 4'd12 : 4'd0) + ((kind_n == KIND_FU_A) ? 4'd2 : 4'd3);
			if (kind_n == KIND_PLAIN) begin
				bu.start_code = 1'b1;
				bu = add_byte(bu, hdr_byte);
			end else if (eff < {8'd0, hdr_need}) begin
				drop_n = 1'b1;
			end
			if (pos_q == 12'd1 && !drop_n) begin
				body_go = 1'b1;
			end
		end

		rel = rtp_n ? (pos_q - RTP_HDR_BYTES) : pos_q;

		if (body_go) begin
			case (kind_n)
				KIND_PLAIN: begin
					bu = add_byte(bu, b);
				end
				KIND_FU_A: begin
					if (rel == 12'd1) begin
						fstart_n = b[7];
						if (b[7]) begin
							bu.start_code = 1'b1;
							bu = add_byte(bu, (nal_n & H264_HDR_KEEP) | (b & H264_TYPE_MASK));
						end
					end else begin
						bu = add_byte(bu, b);
					end
				end
				KIND_FU_H265: begin
					if (rel == 12'd2) begin
						fstart_n = b[7];
						if (b[7]) begin
							bu.start_code = 1'b1;
							bu = add_byte(bu, (nal_n & H265_HDR_KEEP) | {1'b0, b[5:0], 1'b0});
							bu = add_byte(bu, H265_HDR_SECOND);
						end
					end else if (rel >= 12'd3) begin
						bu = add_byte(bu, b);
					end
				end
				default: begin
				end
			endcase
		end

		bu.gap  = gap_n;
		bu.cont = (kind_n != KIND_PLAIN) && !fstart_n;
		bu.last = (p_inc == {1'b0, eff});
		burst   = bu;
		push    = accept && (bu.start_code || bu.n_bytes != 2'd0);
		pos_n   = (p_inc >= {1'b0, len}) ? 12'd0 : p_inc[11:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			held_q    <= '0;
			rtp_q     <= 1'b0;
			nal_q     <= '0;
			kind_q    <= KIND_PLAIN;
			seqhi_q   <= '0;
			lastseq_q <= '0;
			gap_q     <= 1'b0;
			drop_q    <= 1'b0;
			fstart_q  <= 1'b0;
		end else if (accept) begin
			pos_q     <= pos_n;
			held_q    <= held_n;
			rtp_q     <= rtp_n;
			nal_q     <= nal_n;
			kind_q    <= kind_n;
			seqhi_q   <= seqhi_n;
			lastseq_q <= lastseq_n;
			gap_q     <= gap_n;
			drop_q    <= drop_n;
			fstart_q  <= fstart_n;
		end
	end

endmodule

@@ hdl/rtph_queue.sv @@
// ----------------------------------------------------------------------------
// rtph_queue: burst queue between parser and serialiser
// A short first-in first-out store of burst records, so that either side can
// stall without holding up the other.
// ----------------------------------------------------------------------------
module rtph_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rtph_pkg::burst_t push_data,
	input  logic             pop,
	output rtph_pkg::burst_t head,
	output logic             not_empty,
	output logic             full
);
	import rtph_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PW:0] DEPTH_W = (PW + 1)'(QUEUE_DEPTH);
	localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);

	burst_t        store_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign head      = store_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == DEPTH_W);

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/rtph_back.sv @@
// ----------------------------------------------------------------------------
// rtph_back: burst serialiser
// Expands the burst record at the head of the queue into output words, one
// per cycle unless seg_stall holds them, through a registered output stage.
// ----------------------------------------------------------------------------
module rtph_back (
	input  logic               clk,
	input  logic               arst_n,
	input  rtph_pkg::burst_t   head,
	input  logic               not_empty,
	output logic               pop,
	output logic               seg_valid,
	input  logic               seg_stall,
	output rtph_pkg::seg_word_t seg_word
);
	import rtph_pkg::*;

	logic [2:0] idx_q;
	logic       valid_q;
	seg_word_t  word_q;
	logic       advance;
	logic       at_end;
	logic [2:0] lit_idx;
	logic [7:0] sel_byte;

	assign advance = !valid_q || !seg_stall;
	assign at_end  = (idx_q == burst_len(head) - 3'd1);
	assign pop     = advance && not_empty && at_end;
	assign lit_idx = head.start_code ? (idx_q - 3'd4) : idx_q;

	always_comb begin
		if (head.start_code && idx_q < 3'd4) begin
			sel_byte = (idx_q == 3'd3) ? START_CODE_LAST : START_CODE_ZERO;
		end else begin
			sel_byte = (lit_idx == 3'd0) ? head.byte0 : head.byte1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (advance) begin
			valid_q <= not_empty;
			if (not_empty) begin
				idx_q <= at_end ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && not_empty) begin
			word_q.out_byte              <= sel_byte;
			word_q.out_last              <= head.last && at_end;
			word_q.seq_gap               <= head.gap;
			word_q.continuation_fragment <= head.cont;
		end
	end

	assign seg_valid = valid_q;
	assign seg_word  = word_q;

endmodule

@@ hdl/rtp_h26x_depacketizer.sv @@
// ----------------------------------------------------------------------------
// rtp_h26x_depacketizer: RTP to Annex-B depacketiser for H.264 and H.265
// Accepts an RTP packet a byte per word and gives its Annex-B segment a byte
// per word, rebuilding fragmented NAL unit headers and flagging sequence gaps.
// ----------------------------------------------------------------------------
// The block takes one packet byte per cycle on pkt_word while pkt_stall is
// low, with the packet's total length repeated on every byte, and produces
// the Annex-B bytes on seg_word, also at up to one word per cycle. A parser
// accepts each byte offered while the queue is not full, works out the
// output bytes it causes (nothing, a payload byte, or a start code followed
// by a rebuilt NAL header, five or six words in all) and writes them as one
// record into a four-entry queue. A serialiser empties the queue through a
// registered output stage, one word per cycle unless seg_stall holds it.
// Payload bytes therefore stream at one word per cycle while the output is
// not stalled, and pkt_stall rises only once the queue has filled behind a
// stalled or busy output. The words of an accepted byte pass through the
// queue and then the output register. Packets of twelve bytes or fewer are
// discarded, bytes beyond MAX_PACKET_BYTES are counted but ignored, and the
// final word of a packet's segment carries out_last when the packet's last
// byte itself yields output. The flags seq_gap and continuation_fragment are
// constant across the words that one input byte causes.
// ----------------------------------------------------------------------------
module rtp_h26x_depacketizer #(
	parameter int MAX_PACKET_BYTES = rtph_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pkt_valid,
	output logic                pkt_stall,
	input  rtph_pkg::pkt_word_t pkt_word,
	output logic                seg_valid,
	input  logic                seg_stall,
	output rtph_pkg::seg_word_t seg_word
);
	import rtph_pkg::*;

	burst_t push_burst;
	burst_t head_burst;
	logic   push;
	logic   pop;
	logic   q_full;
	logic   q_not_empty;

	// Parser: position, sequence and NAL unit tracking.
	rtph_front #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pkt_valid(pkt_valid),
		.pkt_stall(pkt_stall),
		.pkt_word (pkt_word),
		.q_full   (q_full),
		.push     (push),
		.burst    (push_burst)
	);

	// Decoupling queue: the parser keeps accepting while a burst drains, until the queue fills.
	rtph_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_burst),
		.pop      (pop),
		.head     (head_burst),
		.not_empty(q_not_empty),
		.full     (q_full)
	);

	// Serialiser: one output word per cycle from the head record unless seg_stall holds it.
	rtph_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head_burst),
		.not_empty(q_not_empty),
		.pop      (pop),
		.seg_valid(seg_valid),
		.seg_stall(seg_stall),
		.seg_word (seg_word)
	);

endmodule

@@ hdl/rtph_checker.sv @@
// ----------------------------------------------------------------------------
// rtph_checker: port-level checks for the depacketiser
// Watches the top level's ports and reports handshake and flow control
// violations.
// ----------------------------------------------------------------------------
module rtph_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                pkt_stall,
	input logic                seg_valid,
	input logic                seg_stall,
	input rtph_pkg::seg_word_t seg_word
);
	import rtph_pkg::*;

	// A stalled output word stays offered and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && seg_stall |=> seg_valid && $stable(seg_word))
	else $error("output word changed or withdrawn while stalled");

	// The queue can only be full while an output word waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		!seg_valid |-> !pkt_stall)
	else $error("input stalled with the output stage empty");

	// Input back-pressure is released only by an output word leaving.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(pkt_stall) |-> $past(seg_valid && !seg_stall))
	else $error("input stall released without an output word taken");

endmodule

bind rtp_h26x_depacketizer rtph_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.pkt_stall(pkt_stall),
	.seg_valid(seg_valid),
	.seg_stall(seg_stall),
	.seg_word (seg_word)
);

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the RTP to Annex-B depacketiser
// Feeds RTP packets a byte per word, plain NAL units and H.264 and H.265
// fragments among them, predicts every segment word from its own model of the
// block and compares the words that come out in order, field by field.
// ----------------------------------------------------------------------------
module testbench;

	import rtph_pkg::*;

	// A packet byte waiting to be offered. When drain is set, the sender holds
	// the byte back until every segment word predicted so far has come out.
	typedef struct {
		pkt_word_t word;
		logic      drain;
	} pending_word_t;

	localparam int MAX_BYTES = MAX_PACKET_BYTES_DEF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        pkt_valid = 1'b0;
	logic        pkt_stall;
	pkt_word_t   pkt_word = '0;
	logic        seg_valid;
	logic        seg_stall = 1'b0;
	seg_word_t   seg_word;

	pending_word_t pkt_pending[$];
	seg_word_t     seg_expected[$];
	seg_word_t     seg_step[$];
	seg_word_t     seg_want;

	int unsigned cycles_seen = 0;
	int unsigned seg_seen = 0;
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;
	int          mismatches = 0;

	// Our own copy of the depacketiser state, advanced once per accepted byte.
	logic [11:0] byte_pos = '0;
	logic [7:0]  first_byte = '0;
	logic        rtp_hdr_on = 1'b0;
	logic [7:0]  nal_hdr = '0;
	unit_kind_t  kind = KIND_PLAIN;
	logic [7:0]  seq_hi = '0;
	logic [15:0] prev_seq = '0;
	logic        gap_flag = 1'b0;
	logic        pkt_dropped = 1'b0;
	logic        frag_start = 1'b0;

	rtp_h26x_depacketizer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.pkt_word  (pkt_word),
		.seg_valid (seg_valid),
		.seg_stall (seg_stall),
		.seg_word  (seg_word)
	);

	always #5 clk = ~clk;

	always @(posedge clk)
		cycles_seen <= cycles_seen + 1;

	// Both sides idle at random with a chance of 37 in a hundred, except in a calm
	// window where neither side ever idles.
	function automatic logic idle_now();
		if (cycles_seen >= 100 && cycles_seen < 300)
			return 1'b0;
		return $urandom_range(99) < 37;
	endfunction

	// ------------------------------------------------------------------
	// Segment prediction
	// ------------------------------------------------------------------

	// Every word that one input byte causes carries the flags as they stand
	// at the moment it is produced; out_last is patched on afterwards.
	function automatic void emit_word(input logic [7:0] b);
		seg_word_t w;
		w.out_byte = b;
		w.out_last = 1'b0;
		w.seq_gap = gap_flag;
		w.continuation_fragment = (kind != KIND_PLAIN) && !frag_start;
		seg_step.push_back(w);
	endfunction

	function automatic void emit_start_code();
		emit_word(START_CODE_ZERO);
		emit_word(START_CODE_ZERO);
		emit_word(START_CODE_ZERO);
		emit_word(START_CODE_LAST);
	endfunction

	// The NAL header decides the unit kind. The H.264 FU-A test comes first,
	// so it wins should both type fields ever match. A fragment whose packet
	// cannot hold its FU header is thrown away, though its sequence counts.
	function automatic void take_nal_header(input logic [7:0] n, input int hdr_len,
			input int eff);
		nal_hdr = n;
		if ((n & H264_TYPE_MASK) == H264_FU_A)
			kind = KIND_FU_A;
		else if (n[6:1] == H265_FU)
			kind = KIND_FU_H265;
		else
			kind = KIND_PLAIN;
		if (kind == KIND_PLAIN) begin
			emit_start_code();
			emit_word(n);
		end else if (eff < hdr_len + (kind == KIND_FU_A ? 2 : 3)) begin
			pkt_dropped = 1'b1;
		end
	endfunction

	// rel counts bytes from the NAL header. Only a start fragment gets a start
	// code and a rebuilt header; for H.265 the second payload-header byte is
	// swallowed and replaced by a fixed one.
	function automatic void take_body(input logic [7:0] b, input int rel);
		case (kind)
			KIND_PLAIN: begin
				emit_word(b);
			end
			KIND_FU_A: begin
				if (rel == 1) begin
					frag_start = b[7];
					if (frag_start) begin
						emit_start_code();
						emit_word((nal_hdr & H264_HDR_KEEP) | (b & H264_TYPE_MASK));
					end
				end else begin
					emit_word(b);
				end
			end
			default: begin
				if (rel == 2) begin
					frag_start = b[7];
					if (frag_start) begin
						emit_start_code();
						emit_word((nal_hdr & H265_HDR_KEEP) | {1'b0, b[5:0], 1'b0});
						emit_word(H265_HDR_SECOND);
					end
				end else if (rel >= 3) begin
					emit_word(b);
				end
			end
		endcase
	endfunction

	// Works out the segment words caused by one accepted packet byte and
	// appends them to the store of expected words.
	function automatic void predict_segment(input pkt_word_t w);
		int        len;
		int        eff;
		int        p;
		logic [7:0] b;
		logic [15:0] seq;
		seg_word_t tail;
		b = w.in_byte;
		len = int'(w.packet_length);
		eff = (len < MAX_BYTES) ? len : MAX_BYTES;
		p = int'(byte_pos);
		seg_step.delete();
		if (p == 0) begin
			gap_flag = 1'b0;
			frag_start = 1'b0;
			kind = KIND_PLAIN;
			rtp_hdr_on = 1'b0;
			pkt_dropped = (eff <= RTP_HDR_BYTES);
			first_byte = b;
		end else if (p < eff && !pkt_dropped) begin
			if (p == 1) begin
				rtp_hdr_on = ((first_byte & RTP_VERSION_MASK) != 0)
						&& ((b & RTP_SECOND_MASK) != 0);
				if (!rtp_hdr_on) begin
					take_nal_header(first_byte, 0, eff);
					if (!pkt_dropped)
						take_body(b, 1);
				end
			end else begin
				if (p == 2) begin
					seq_hi = b;
				end else if (p == 3) begin
					seq = {seq_hi, b};
					gap_flag = (prev_seq != 0) && (prev_seq + 16'd1 != seq);
					prev_seq = seq;
				end
				if (!rtp_hdr_on)
					take_body(b, p);
				else if (p == RTP_HDR_BYTES)
					take_nal_header(b, int'(RTP_HDR_BYTES), eff);
				else if (p > RTP_HDR_BYTES)
					take_body(b, p - int'(RTP_HDR_BYTES));
			end
		end
		// out_last only when the packet's final byte itself produced words.
		if (seg_step.size() != 0 && p + 1 == eff) begin
			tail = seg_step[seg_step.size() - 1];
			tail.out_last = 1'b1;
			seg_step[seg_step.size() - 1] = tail;
		end
		byte_pos = (p + 1 >= len) ? 12'd0 : 12'(p + 1);
		foreach (seg_step[i])
			seg_expected.push_back(seg_step[i]);
	endfunction

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	task automatic queue_word(input logic [7:0] b, input logic [11:0] len,
			input logic drain);
		pending_word_t pw;
		pw.word.in_byte = b;
		pw.word.packet_length = len;
		pw.drain = drain;
		pkt_pending.push_back(pw);
	endtask

	// Queues a whole packet. The sequence number goes into bytes 2 and 3 and
	// the three NAL header bytes follow the RTP header, or start the packet
	// when there is none; header bytes take precedence where the two overlap.
	task automatic queue_packet(input logic rtp, input logic [15:0] seq,
			input logic [7:0] h0, input logic [7:0] h1, input logic [7:0] h2,
			input int total, input logic drain);
		int         off;
		logic [7:0] b;
		off = rtp ? int'(RTP_HDR_BYTES) : 0;
		for (int i = 0; i < total; i++) begin
			b = 8'($urandom_range(255));
			if (rtp && i == 0)
				b = {2'b10, b[5:0]};
			if (rtp && i == 1 && (b & RTP_SECOND_MASK) == 0)
				b = b | RTP_SECOND_MASK;
			if (i == 2)
				b = seq[15:8];
			if (i == 3)
				b = seq[7:0];
			if (i == off)
				b = h0;
			else if (i == off + 1)
				b = h1;
			else if (i == off + 2)
				b = h2;
			queue_word(b, total[11:0], drain && i == 0);
		end
	endtask

	// Packet bytes are offered at the clock edge. A byte that was taken is
	// predicted at once, in the same process, so every expectation is in place
	// long before its word can leave the block.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_valid <= 1'b0;
			pkt_word <= '0;
		end else begin
			if (pkt_valid && !pkt_stall)
				predict_segment(pkt_word);
			if (!pkt_valid || !pkt_stall) begin
				if (pkt_pending.size() != 0 && !idle_now()
						&& !(pkt_pending[0].drain && seg_expected.size() != 0)) begin
					pkt_valid <= 1'b1;
					pkt_word <= pkt_pending[0].word;
					pkt_pending.delete(0);
				end else begin
					pkt_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Segment checking
	// ------------------------------------------------------------------

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatches++;
		end
	endfunction

	// Words are sampled at the clock edge, before the block updates them. Once
	// sixty words have arrived, the receiver holds off for a long stretch so
	// that the internal queue fills and the block has to stall its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_stall <= 1'b0;
		end else begin
			if (seg_valid && !seg_stall) begin
				if (seg_expected.size() == 0) begin
					$error("segment word %h arrived with nothing expected", seg_word);
					mismatches++;
				end else begin
					seg_want = seg_expected.pop_front();
					check_field("out_byte", seg_want.out_byte, seg_word.out_byte);
					check_field("out_last", 8'(seg_want.out_last),
						8'(seg_word.out_last));
					check_field("seq_gap", 8'(seg_want.seq_gap), 8'(seg_word.seq_gap));
					check_field("continuation_fragment",
						8'(seg_want.continuation_fragment),
						8'(seg_word.continuation_fragment));
				end
				seg_seen++;
			end
			if (hold_left != 0) begin
				hold_left--;
				seg_stall <= 1'b1;
			end else if (seg_seen >= 60 && !hold_done) begin
				hold_done = 1'b1;
				hold_left = 150;
				seg_stall <= 1'b1;
			end else begin
				seg_stall <= idle_now();
			end
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------

	initial begin : stimulus
		logic [15:0] sn;
		logic [7:0]  nal;
		logic [7:0]  fu_hdr;
		int          total;
		int          pick;
		int          rand_items;
		logic        first;

		// Plain NAL units, the shortest useful packet and short packets that
		// are dropped without touching the sequence number.
		queue_packet(1'b1, 16'd100, 8'h41, 8'h00, 8'hFF, 16, 1'b0);
		queue_packet(1'b1, 16'd101, 8'h67, 8'h00, 8'h00, 13, 1'b0);
		queue_packet(1'b1, 16'd102, 8'h68, 8'hFF, 8'hFF, 12, 1'b0);
		queue_word(8'hFF, 12'd1, 1'b0);
		// An H.264 FU-A unit split into start, middle and end fragments, and
		// a fragment too short to carry its FU header.
		queue_packet(1'b1, 16'd102, 8'h7C, 8'h85, 8'hAA, 18, 1'b0);
		queue_packet(1'b1, 16'd103, 8'h7C, 8'h05, 8'h55, 16, 1'b0);
		queue_packet(1'b1, 16'd104, 8'h7C, 8'h45, 8'h00, 15, 1'b0);
		queue_packet(1'b1, 16'd105, 8'h7C, 8'h85, 8'h00, 13, 1'b0);
		// The same for H.265. The end fragment stops on its FU header, so its
		// final byte yields nothing and no word carries out_last.
		queue_packet(1'b1, 16'd106, 8'h62, 8'h01, 8'h93, 18, 1'b0);
		queue_packet(1'b1, 16'd107, 8'h63, 8'h01, 8'h13, 16, 1'b0);
		queue_packet(1'b1, 16'd108, 8'h62, 8'h01, 8'h53, 15, 1'b0);
		queue_packet(1'b1, 16'd109, 8'h62, 8'h01, 8'h93, 14, 1'b0);
		// A sequence jump, then a wrap through zero, which is no gap.
		queue_packet(1'b1, 16'd300, 8'h41, 8'h11, 8'h22, 14, 1'b0);
		queue_packet(1'b1, 16'hFFFF, 8'h41, 8'h11, 8'h22, 14, 1'b0);
		queue_packet(1'b1, 16'h0000, 8'h41, 8'h11, 8'h22, 14, 1'b0);
		queue_packet(1'b1, 16'h0001, 8'h01, 8'h11, 8'h22, 14, 1'b0);
		// Packets without RTP header: the gap flag only settles on byte 3, so
		// the first words of the first one carry it low.
		queue_packet(1'b0, 16'h1234, 8'h65, 8'h80, 8'h7F, 16, 1'b0);
		queue_packet(1'b0, 16'h0000, 8'h81, 8'h11, 8'h00, 14, 1'b0);
		queue_packet(1'b0, 16'h4321, 8'h5C, 8'h87, 8'h00, 14, 1'b0);
		// The length changes from byte to byte: each byte's own length ends the
		// packet, and a length of zero ends it on every byte.
		queue_word(8'h80, 12'hFFF, 1'b0);
		queue_word(8'h00, 12'd2, 1'b0);
		queue_word(8'h55, 12'd0, 1'b0);
		queue_word(8'hC3, 12'd0, 1'b0);
		queue_word(8'h80, 12'd20, 1'b0);
		queue_word(8'hE0, 12'd20, 1'b0);
		queue_word(8'h12, 12'd3, 1'b0);

		// Random packets, mostly well formed with random content, some noise.
		// The first one is offered only after the pipeline has drained.
		sn = 16'd501;
		rand_items = 0;
		first = 1'b1;
		while (rand_items < 40) begin
			pick = $urandom_range(99);
			if ($urandom_range(7) == 0)
				sn = 16'($urandom_range(65535));
			else
				sn = sn + 16'd1;
			total = $urandom_range(20, 13);
			fu_hdr = 8'($urandom_range(255));
			fu_hdr[7] = ($urandom_range(2) == 0);
			nal = 8'($urandom_range(255));
			nal[7] = 1'b0;
			if (pick < 35) begin
				if (nal[4:0] == H264_FU_A[4:0] || nal[6:1] == H265_FU)
					nal = nal ^ 8'h02;
				queue_packet(1'b1, sn, nal, 8'($urandom_range(255)),
					8'($urandom_range(255)), total, first);
			end else if (pick < 60) begin
				nal[4:0] = H264_FU_A[4:0];
				queue_packet(1'b1, sn, nal, fu_hdr, 8'($urandom_range(255)), total,
					first);
			end else if (pick < 80) begin
				nal[6:1] = H265_FU;
				queue_packet(1'b1, sn, nal, 8'($urandom_range(255)), fu_hdr, total,
					first);
			end else if (pick < 90) begin
				queue_packet(1'b0, sn, 8'($urandom_range(255)),
					8'($urandom_range(255)) & 8'h9F,
					8'($urandom_range(255)), total, first);
			end else if (pick < 95) begin
				total = $urandom_range(12, 1);
				queue_packet(1'($urandom_range(1)), sn, 8'($urandom_range(255)),
					8'($urandom_range(255)), 8'($urandom_range(255)), total, first);
			end else begin
				// Fragments cut off before or right at their FU header, or for H.264 one byte after it.
				total = $urandom_range(15, 13);
				if (pick < 98)
					nal[4:0] = H264_FU_A[4:0];
				else
					nal[6:1] = H265_FU;
				queue_packet(1'b1, sn, nal, fu_hdr, fu_hdr, total, first);
			end
			if (total > RTP_HDR_BYTES)
				rand_items += total;
			first = 1'b0;
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pkt_pending.size() != 0 || pkt_valid)
			@(posedge clk);
		while (seg_expected.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && seg_expected.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// A hung handshake ends the run here.
	initial begin
		#3000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
